FILE: rtl/core/iwcs_pkg.sv
// Shared types, constants and the microcode program of the wall-centering steering block.
// Used by the sequencer, the datapath and the top level; it depends on nothing else.
`default_nettype none

package iwcs_pkg;

    localparam int ACC_W   = 34;  // Horner accumulator, holds the sum of all coefficient magnitudes
    localparam int COEF_W  = 32;
    localparam int DIST_W  = 17;
    localparam int CORR_W  = 10;
    localparam int DUTY_W  = 8;
    localparam int CFG_W   = 8;
    localparam int UPC_W   = 5;
    localparam int CNT_W   = 3;
    localparam int QUO_W   = 9;
    localparam int REM_W   = 20;
    localparam int DSR_W   = 16;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_START  = 2'd1,
        OP_STOP   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CFG_BASE_SPEED       = 2'd0,
        CFG_MIN_SPEED        = 2'd1,
        CFG_MAX_SPEED_CHANGE = 2'd2,
        CFG_TARGET_DISTANCE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MS_NONE  = 2'd0,
        MS_LEFT  = 2'd1,
        MS_RIGHT = 2'd2,
        MS_CORR  = 2'd3
    } t_mul_sel;

    typedef enum logic [1:0] {
        UP_NONE  = 2'd0,
        UP_LEFT  = 2'd1,
        UP_RIGHT = 2'd2
    } t_upd;

    typedef enum logic [2:0] {
        AL_NOP  = 3'd0,
        AL_FIN  = 3'd1,
        AL_DIFF = 3'd2,
        AL_CMP  = 3'd3,
        AL_DIV  = 3'd4,
        AL_SIGN = 3'd5,
        AL_DUTY = 3'd6
    } t_alu_op;

    typedef enum logic [1:0] {
        JC_NEVER   = 2'd0,
        JC_STOPPED = 2'd1,
        JC_SAT     = 2'd2,
        JC_LOOP    = 2'd3
    } t_jump_cond;

    typedef struct packed {
        t_mul_sel          mul_sel;
        t_upd              upd;
        logic [2:0]        coef_idx;
        t_alu_op           alu;
        t_jump_cond        jc;
        logic [UPC_W-1:0]  target;
        logic              last;
    } t_ctrl;

    // Branch conditions seen by the sequencer.
    typedef struct packed {
        logic stopped;
        logic sat;
    } t_cond;

    localparam logic [UPC_W-1:0] UPC_DIV  = 5'd14;
    localparam logic [UPC_W-1:0] UPC_SIGN = 5'd15;
    localparam logic [UPC_W-1:0] UPC_OUT  = 5'd18;
    localparam logic [CNT_W-1:0] DIV_LAST = 3'd7;

    // Left polynomial coefficients, scaled by 2^16, index is the power of u.
    function automatic logic signed [COEF_W-1:0] left_coef(input logic [2:0] k);
        logic signed [COEF_W-1:0] c;
        case (k)
            3'd0:    c = 32'sd6680079;
            3'd1:    c = -32'sd63401770;
            3'd2:    c = 32'sd288196908;
            3'd3:    c = -32'sd699224826;
            3'd4:    c = 32'sd861254269;
            3'd5:    c = -32'sd422201110;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] right_coef(input logic [2:0] k);
        logic signed [COEF_W-1:0] c;
        case (k)
            3'd0:    c = 32'sd7764283;
            3'd1:    c = -32'sd77239014;
            3'd2:    c = 32'sd358417093;
            3'd3:    c = -32'sd873658034;
            3'd4:    c = 32'sd1073592202;
            3'd5:    c = -32'sd523692364;
            default: c = '0;
        endcase
        return c;
    endfunction

    // The program. Steps 0 to 10 interleave the two Horner evaluations on one
    // multiplier: each of steps 1 to 9 multiplies one side while the other side adds
    // its coefficient to the product of the previous step.
    function automatic t_ctrl ucode(input logic [UPC_W-1:0] pc);
        t_ctrl c;
        c = '0;
        case (pc)
            5'd0:  begin c.mul_sel = MS_LEFT;  end
            5'd1:  begin c.mul_sel = MS_RIGHT; c.upd = UP_LEFT;  c.coef_idx = 3'd4; end
            5'd2:  begin c.mul_sel = MS_LEFT;  c.upd = UP_RIGHT; c.coef_idx = 3'd4; end
            5'd3:  begin c.mul_sel = MS_RIGHT; c.upd = UP_LEFT;  c.coef_idx = 3'd3; end
            5'd4:  begin c.mul_sel = MS_LEFT;  c.upd = UP_RIGHT; c.coef_idx = 3'd3; end
            5'd5:  begin c.mul_sel = MS_RIGHT; c.upd = UP_LEFT;  c.coef_idx = 3'd2; end
            5'd6:  begin c.mul_sel = MS_LEFT;  c.upd = UP_RIGHT; c.coef_idx = 3'd2; end
            5'd7:  begin c.mul_sel = MS_RIGHT; c.upd = UP_LEFT;  c.coef_idx = 3'd1; end
            5'd8:  begin c.mul_sel = MS_LEFT;  c.upd = UP_RIGHT; c.coef_idx = 3'd1; end
            5'd9:  begin c.mul_sel = MS_RIGHT; c.upd = UP_LEFT;  c.coef_idx = 3'd0; end
            5'd10: begin c.upd = UP_RIGHT; c.coef_idx = 3'd0; end
            5'd11: begin c.alu = AL_FIN; c.jc = JC_STOPPED; c.target = UPC_OUT; end
            5'd12: begin c.alu = AL_DIFF; end
            5'd13: begin c.alu = AL_CMP; c.jc = JC_SAT; c.target = UPC_SIGN; end
            5'd14: begin c.alu = AL_DIV; c.jc = JC_LOOP; c.target = UPC_DIV; end
            5'd15: begin c.alu = AL_SIGN; end
            5'd16: begin c.mul_sel = MS_CORR; end
            5'd17: begin c.alu = AL_DUTY; end
            5'd18: begin c.last = 1'b1; end
            default: begin c.last = 1'b1; end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ir_wall_centering_steering.sv
// Top level of the infrared wall-centering steering block: handshakes, configuration
// registers, run state and the output register. Depends on iwcs_pkg, iwcs_useq, iwcs_dpath.
//
// Usage. A request on the input channel carries an op code and two sensor samples.
// A start or stop request only sets or clears the run state and gives no result.
// A sample request gives exactly one result: both linearized distances, the
// steering correction and the two wheel duties. While the block is stopped the
// correction and duties are zero. Op code three is dropped.
// The two fifth-order polynomials share one multiplier, interleaved over 11
// steps, and the correction comes from a divider that produces one quotient
// bit per cycle, so one sample occupies the block until its result is handed to
// the output register, and o_in_stall stays high meanwhile.
// The result sits in an output register, so a stalled receiver does not stop a
// new request from being accepted; only the next result waits, holding the
// sequencer on its final step, until the register is free again.
// Configuration writes take effect at once and belong in idle periods.
// A synchronous reset restores the register defaults, stops the block and
// empties the output register.
`default_nettype none

module ir_wall_centering_steering #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_in_valid,
    output logic                                   o_in_stall,
    input  wire        [1:0]                       i_op,
    input  wire        [SAMPLE_BITS-1:0]           i_left_sample,
    input  wire        [SAMPLE_BITS-1:0]           i_right_sample,
    output logic                                   o_out_valid,
    input  wire                                    i_out_stall,
    output logic       [iwcs_pkg::DUTY_W-1:0]      o_left_duty,
    output logic       [iwcs_pkg::DUTY_W-1:0]      o_right_duty,
    output logic signed [iwcs_pkg::CORR_W-1:0]     o_correction,
    output logic signed [iwcs_pkg::DIST_W-1:0]    o_left_distance,
    output logic signed [iwcs_pkg::DIST_W-1:0]    o_right_distance,
    input  wire                                    i_cfg_we,
    input  wire        [1:0]                       i_cfg_index,
    input  wire        [iwcs_pkg::CFG_W-1:0]       i_cfg_data
);

    logic [iwcs_pkg::CFG_W-1:0]    r_base_speed;
    logic [iwcs_pkg::CFG_W-1:0]    r_min_speed;
    logic [iwcs_pkg::CFG_W-1:0]    r_max_speed_change;
    logic [iwcs_pkg::CFG_W-1:0]    r_target_distance;
    logic                          r_running;
    logic                          r_out_valid;
    logic [iwcs_pkg::DUTY_W-1:0]   r_left_duty;
    logic [iwcs_pkg::DUTY_W-1:0]   r_right_duty;
    logic signed [iwcs_pkg::CORR_W-1:0]  r_correction;
    logic signed [iwcs_pkg::DIST_W-1:0]  r_left_distance;
    logic signed [iwcs_pkg::DIST_W-1:0]  r_right_distance;

    logic                          busy;
    logic                          done;
    logic                          in_take;
    logic                          start;
    logic                          out_free;
    iwcs_pkg::t_ctrl               ctrl;
    iwcs_pkg::t_cond               cond;
    logic                          dp_sat;
    logic [iwcs_pkg::DUTY_W-1:0]   dp_left_duty;
    logic [iwcs_pkg::DUTY_W-1:0]   dp_right_duty;
    logic signed [iwcs_pkg::CORR_W-1:0]  dp_correction;
    logic signed [iwcs_pkg::DIST_W-1:0]  dp_left_distance;
    logic signed [iwcs_pkg::DIST_W-1:0]  dp_right_distance;

    // Requests are taken whenever no sample is in the sequencer.
    assign o_in_stall = busy;
    assign in_take    = i_in_valid && !busy;
    assign start      = in_take && (iwcs_pkg::t_op'(i_op) == iwcs_pkg::OP_SAMPLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign cond.stopped = !r_running;
    assign cond.sat     = dp_sat;

    iwcs_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .i_cond     (cond),
        .o_ctrl     (ctrl),
        .o_busy     (busy),
        .o_done     (done)
    );

    iwcs_dpath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_start            (start),
        .i_left_sample      (i_left_sample),
        .i_right_sample     (i_right_sample),
        .i_ctrl             (ctrl),
        .i_base_speed       (r_base_speed),
        .i_min_speed        (r_min_speed),
        .i_max_speed_change (r_max_speed_change),
        .i_target_distance  (r_target_distance),
        .o_sat              (dp_sat),
        .o_left_duty        (dp_left_duty),
        .o_right_duty       (dp_right_duty),
        .o_correction       (dp_correction),
        .o_left_distance    (dp_left_distance),
        .o_right_distance   (dp_right_distance)
    );

    // Configuration registers and run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_speed       <= 8'd150;
            r_min_speed        <= 8'd90;
            r_max_speed_change <= 8'd100;
            r_target_distance  <= 8'd20;
            r_running          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (iwcs_pkg::t_cfg_idx'(i_cfg_index))
                    iwcs_pkg::CFG_BASE_SPEED:       r_base_speed       <= i_cfg_data;
                    iwcs_pkg::CFG_MIN_SPEED:        r_min_speed        <= i_cfg_data;
                    iwcs_pkg::CFG_MAX_SPEED_CHANGE: r_max_speed_change <= i_cfg_data;
                    iwcs_pkg::CFG_TARGET_DISTANCE:  r_target_distance  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (in_take) begin
                case (iwcs_pkg::t_op'(i_op))
                    iwcs_pkg::OP_START: r_running <= 1'b1;
                    iwcs_pkg::OP_STOP:  r_running <= 1'b0;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register: loaded when the sequencer finishes, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_left_duty      <= dp_left_duty;
            r_right_duty     <= dp_right_duty;
            r_correction     <= dp_correction;
            r_left_distance  <= dp_left_distance;
            r_right_distance <= dp_right_distance;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_left_duty      = r_left_duty;
    assign o_right_duty     = r_right_duty;
    assign o_correction     = r_correction;
    assign o_left_distance  = r_left_distance;
    assign o_right_distance = r_right_distance;

endmodule

`default_nettype wire

FILE: rtl/core/iwcs_useq.sv
// Microcode sequencer: step counter, loop counter and program table lookup.
// Depends on iwcs_pkg for the control word, the branch conditions and the program.
`default_nettype none

module iwcs_useq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_out_free,
    input  iwcs_pkg::t_cond     i_cond,
    output iwcs_pkg::t_ctrl     o_ctrl,
    output logic                o_busy,
    output logic                o_done
);

    logic                          r_busy;
    logic [iwcs_pkg::UPC_W-1:0]    r_upc;
    logic [iwcs_pkg::UPC_W-1:0]    n_upc;
    logic [iwcs_pkg::CNT_W-1:0]    r_cnt;
    logic [iwcs_pkg::CNT_W-1:0]    n_cnt;
    iwcs_pkg::t_ctrl               rom_word;
    logic                          take_jump;

    assign rom_word = iwcs_pkg::ucode(r_upc);

    always_comb begin
        case (rom_word.jc)
            iwcs_pkg::JC_STOPPED: take_jump = i_cond.stopped;
            iwcs_pkg::JC_SAT:     take_jump = i_cond.sat;
            iwcs_pkg::JC_LOOP:    take_jump = (r_cnt != '0);
            default:              take_jump = 1'b0;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (r_busy && rom_word.alu == iwcs_pkg::AL_CMP) begin
            n_cnt = iwcs_pkg::DIV_LAST;
        end else if (r_busy && rom_word.alu == iwcs_pkg::AL_DIV && r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
        end
        if (take_jump) begin
            n_upc = rom_word.target;
        end else begin
            n_upc = r_upc + 1'b1;
        end
    end

    // The final step waits there until the output register can take the result.
    assign o_done = r_busy && rom_word.last && i_out_free;
    assign o_busy = r_busy;
    assign o_ctrl = r_busy ? rom_word : iwcs_pkg::t_ctrl'('0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_start) begin
                r_busy <= 1'b1;
                r_upc  <= '0;
            end else if (o_done) begin
                r_busy <= 1'b0;
            end else if (r_busy && !rom_word.last) begin
                r_upc <= n_upc;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/iwcs_dpath.sv
// Datapath: one shared multiplier, Horner accumulators, rounding, the restoring
// divider for the correction and the duty arithmetic. Depends on iwcs_pkg.
`default_nettype none

module iwcs_dpath #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire                                    i_clk,
    input  wire                                    i_start,
    input  wire        [SAMPLE_BITS-1:0]           i_left_sample,
    input  wire        [SAMPLE_BITS-1:0]           i_right_sample,
    input  iwcs_pkg::t_ctrl                        i_ctrl,
    input  wire        [iwcs_pkg::CFG_W-1:0]       i_base_speed,
    input  wire        [iwcs_pkg::CFG_W-1:0]       i_min_speed,
    input  wire        [iwcs_pkg::CFG_W-1:0]       i_max_speed_change,
    input  wire        [iwcs_pkg::CFG_W-1:0]       i_target_distance,
    output logic                                   o_sat,
    output logic       [iwcs_pkg::DUTY_W-1:0]      o_left_duty,
    output logic       [iwcs_pkg::DUTY_W-1:0]      o_right_duty,
    output logic signed [iwcs_pkg::CORR_W-1:0]     o_correction,
    output logic signed [iwcs_pkg::DIST_W-1:0]    o_left_distance,
    output logic signed [iwcs_pkg::DIST_W-1:0]    o_right_distance
);

    localparam int AW = iwcs_pkg::ACC_W;
    localparam int BW = SAMPLE_BITS + 1;
    localparam int PW = AW + BW;

    logic        [SAMPLE_BITS-1:0]          r_xl;
    logic        [SAMPLE_BITS-1:0]          r_xr;
    logic signed [AW-1:0]                   r_accl;
    logic signed [AW-1:0]                   r_accr;
    logic signed [PW-1:0]                   r_prod;
    logic signed [iwcs_pkg::DIST_W-1:0]     r_distl;
    logic signed [iwcs_pkg::DIST_W-1:0]     r_distr;
    logic        [iwcs_pkg::REM_W-1:0]      r_rem;
    logic        [iwcs_pkg::DSR_W-1:0]      r_dsr;
    logic        [iwcs_pkg::QUO_W-1:0]      r_quo;
    logic                                   r_neg;
    logic signed [iwcs_pkg::CORR_W-1:0]     r_corr;
    logic        [iwcs_pkg::DUTY_W-1:0]     r_lduty;
    logic        [iwcs_pkg::DUTY_W-1:0]     r_rduty;

    logic signed [AW-1:0]                   mul_a;
    logic signed [BW-1:0]                   mul_b;
    logic signed [PW-1:0]                   prod_sh;
    logic signed [iwcs_pkg::COEF_W-1:0]     coef;
    logic signed [AW-1:0]                   acc_sum;
    logic signed [iwcs_pkg::DIST_W:0]       diff;
    logic signed [iwcs_pkg::REM_W-1:0]      num4;
    logic        [iwcs_pkg::REM_W-1:0]      mag;
    logic        [iwcs_pkg::REM_W-1:0]      lim;
    logic signed [18:0]                     base_sh;
    logic signed [18:0]                     prod_c;
    logic signed [18:0]                     lsum;
    logic signed [18:0]                     rsum;

    // Rounds the 2^-16 cm accumulator to 1/64 cm and saturates to the field range.
    function automatic logic signed [iwcs_pkg::DIST_W-1:0] to_dist(
        input logic signed [AW-1:0] acc
    );
        logic signed [AW:0]  rnd;
        logic signed [AW-10:0] sh;
        logic signed [iwcs_pkg::DIST_W-1:0] d;
        rnd = {acc[AW-1], acc} + (AW+1)'(512);
        sh  = rnd[AW:10];
        if (sh < -(AW-9)'(65536)) begin
            d = -17'sd65536;
        end else if (sh > (AW-9)'(65535)) begin
            d = 17'sd65535;
        end else begin
            d = sh[iwcs_pkg::DIST_W-1:0];
        end
        return d;
    endfunction

    // Takes base*256 +/- correction*change, floors to whole duty and clamps.
    function automatic logic [iwcs_pkg::DUTY_W-1:0] to_duty(
        input logic signed [18:0] sum,
        input logic [iwcs_pkg::CFG_W-1:0] lo
    );
        logic signed [10:0] v;
        logic [iwcs_pkg::DUTY_W-1:0] d;
        v = sum[18:8];
        if (v < $signed({3'b000, lo})) begin
            d = lo;
        end else if (v > 11'sd255) begin
            d = 8'd255;
        end else begin
            d = v[7:0];
        end
        return d;
    endfunction

    always_comb begin
        case (i_ctrl.mul_sel)
            iwcs_pkg::MS_LEFT: begin
                mul_a = r_accl;
                mul_b = $signed({1'b0, r_xl});
            end
            iwcs_pkg::MS_RIGHT: begin
                mul_a = r_accr;
                mul_b = $signed({1'b0, r_xr});
            end
            iwcs_pkg::MS_CORR: begin
                mul_a = {{(AW-iwcs_pkg::CORR_W){r_corr[iwcs_pkg::CORR_W-1]}}, r_corr};
                mul_b = $signed({{(BW-iwcs_pkg::CFG_W){1'b0}}, i_max_speed_change});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_sh = r_prod >>> SAMPLE_BITS;
    assign coef    = (i_ctrl.upd == iwcs_pkg::UP_LEFT) ? iwcs_pkg::left_coef(i_ctrl.coef_idx)
                                                        : iwcs_pkg::right_coef(i_ctrl.coef_idx);
    assign acc_sum = prod_sh[AW-1:0]
                   + {{(AW-iwcs_pkg::COEF_W){coef[iwcs_pkg::COEF_W-1]}}, coef};

    assign diff = {r_distl[iwcs_pkg::DIST_W-1], r_distl}
                - {r_distr[iwcs_pkg::DIST_W-1], r_distr};
    assign num4 = {diff, 2'b00};
    assign mag  = num4[iwcs_pkg::REM_W-1] ? iwcs_pkg::REM_W'(-num4) : num4;
    assign lim  = {4'b0000, i_target_distance, 8'h00};

    // A zero difference gives zero; otherwise a quotient of 256 or more clamps.
    assign o_sat = (r_rem == '0) || (r_rem >= lim);

    assign base_sh = {3'b000, i_base_speed, 8'h00};
    assign prod_c  = {r_prod[17], r_prod[17:0]};
    assign lsum    = base_sh + prod_c;
    assign rsum    = base_sh - prod_c;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_xl    <= i_left_sample;
            r_xr    <= i_right_sample;
            r_accl  <= {{(AW-iwcs_pkg::COEF_W){1'b1}}, iwcs_pkg::left_coef(3'd5)};
            r_accr  <= {{(AW-iwcs_pkg::COEF_W){1'b1}}, iwcs_pkg::right_coef(3'd5)};
            r_corr  <= '0;
            r_lduty <= '0;
            r_rduty <= '0;
        end else begin
            if (i_ctrl.upd == iwcs_pkg::UP_LEFT) begin
                r_accl <= acc_sum;
            end
            if (i_ctrl.upd == iwcs_pkg::UP_RIGHT) begin
                r_accr <= acc_sum;
            end
            case (i_ctrl.alu)
                iwcs_pkg::AL_FIN: begin
                    r_distl <= to_dist(r_accl);
                    r_distr <= to_dist(r_accr);
                end
                iwcs_pkg::AL_DIFF: begin
                    r_rem <= mag;
                    r_neg <= num4[iwcs_pkg::REM_W-1];
                end
                iwcs_pkg::AL_CMP: begin
                    r_dsr <= {1'b0, i_target_distance, 7'h00};
                    if (r_rem != '0 && r_rem >= lim) begin
                        r_quo <= iwcs_pkg::QUO_W'(256);
                    end else begin
                        r_quo <= '0;
                    end
                end
                iwcs_pkg::AL_DIV: begin
                    if (r_rem >= {4'b0000, r_dsr}) begin
                        r_rem <= r_rem - {4'b0000, r_dsr};
                        r_quo <= {r_quo[iwcs_pkg::QUO_W-2:0], 1'b1};
                    end else begin
                        r_quo <= {r_quo[iwcs_pkg::QUO_W-2:0], 1'b0};
                    end
                    r_dsr <= r_dsr >> 1;
                end
                iwcs_pkg::AL_SIGN: begin
                    r_corr <= r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
                end
                iwcs_pkg::AL_DUTY: begin
                    r_lduty <= to_duty(lsum, i_min_speed);
                    r_rduty <= to_duty(rsum, i_min_speed);
                end
                default: begin
                end
            endcase
        end
        if (i_ctrl.mul_sel != iwcs_pkg::MS_NONE) begin
            r_prod <= mul_a * mul_b;
        end
    end

    assign o_left_duty      = r_lduty;
    assign o_right_duty     = r_rduty;
    assign o_correction     = r_corr;
    assign o_left_distance  = r_distl;
    assign o_right_distance = r_distr;

endmodule

`default_nettype wire
